// ----- rtl/smvg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the sphere mesh vertex generator.
package smvg_pkg;

    // Upper bound on the ring and azimuth division counts
    localparam int MAX_DIVISIONS = 1024;

    // Index fields of the input word
    localparam int IDX_W = 10;
    // Corner coordinates carry one extra bit (index plus one)
    localparam int CRD_W = IDX_W + 1;
    // Raw width of a division register
    localparam int CFG_DIV_W = 11;
    // Effective division count and remainder widths
    localparam int DEN_W = $clog2(MAX_DIVISIONS + 1);
    localparam int REM_W = $clog2(MAX_DIVISIONS);
    // Divider numerator: corner coordinate times a full turn (2^32)
    localparam int NUM_W = CRD_W + 32;

    // Q.30 datapath width (values up to 2^30 and coefficients below 2^31)
    localparam int Q_W = 31;
    localparam int QSIN_LAT = 6;

    localparam logic [Q_W-1:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [Q_W-1:0] C1         = 31'd1686629713;
    localparam logic [Q_W-1:0] C3         = 31'd693598668;
    localparam logic [Q_W-1:0] C5         = 31'd85569305;
    localparam logic [Q_W-1:0] C7         = 31'd5026995;
    localparam logic [Q_W-1:0] C9         = 31'd172273;
    localparam logic [Q_W-1:0] TWO_PI_Q28 = 31'd1686629713;

    localparam logic [2:0] LAST_CORNER = 3'd5;

    // Register map index (byte address / 4)
    typedef enum logic [1:0] {
        REG_RADIUS   = 2'd0,
        REG_AZ_DIV   = 2'd1,
        REG_RING_DIV = 2'd2
    } reg_index_t;

    // Effective configuration seen by the datapath
    typedef struct packed {
        logic [15:0]      radius;
        logic [DEN_W-1:0] az_div;
        logic [DEN_W-1:0] ring_div;
    } cfg_t;

    // One corner leaving the sequencer
    typedef struct packed {
        logic             vld;
        logic [CRD_W-1:0] ring;
        logic [CRD_W-1:0] azim;
        logic [2:0]       corner;
        logic             last;
    } corner_t;

    // Ring offset of each corner: (i,j) (i+1,j) (i,j+1) (i+1,j) (i+1,j+1) (i,j+1)
    function automatic logic corner_dr(input logic [2:0] k);
        logic d;
        case (k)
            3'd1, 3'd3, 3'd4: d = 1'b1;
            default:          d = 1'b0;
        endcase
        return d;
    endfunction

    function automatic logic corner_da(input logic [2:0] k);
        logic d;
        case (k)
            3'd2, 3'd4, 3'd5: d = 1'b1;
            default:          d = 1'b0;
        endcase
        return d;
    endfunction

    // Zero acts as one, large values clip to the maximum
    function automatic logic [DEN_W-1:0] eff_div(input logic [CFG_DIV_W-1:0] d);
        logic [DEN_W-1:0] r;
        if (d == '0) begin
            r = DEN_W'(1);
        end else if (32'(d) > MAX_DIVISIONS) begin
            r = DEN_W'(MAX_DIVISIONS);
        end else begin
            r = DEN_W'(d);
        end
        return r;
    endfunction

    // (a * b) >> 30, for operands whose scaled product stays below 2^31
    function automatic logic [Q_W-1:0] mul_q30(input logic [Q_W-1:0] a,
                                               input logic [Q_W-1:0] b);
        logic [2*Q_W-1:0] p;
        p = (2*Q_W)'(a) * (2*Q_W)'(b);
        return p[Q_W+29:30];
    endfunction

endpackage

// ----- rtl/smvg_cfg.sv -----
`timescale 1ns / 1ps
// APB register file holding radius and division counts.
module smvg_cfg import smvg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [15:0]          radius_reg;
    logic [CFG_DIV_W-1:0] az_div_reg;
    logic [CFG_DIV_W-1:0] ring_div_reg;
    reg_index_t           idx;
    logic                 wr;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= 16'd256;
            az_div_reg   <= CFG_DIV_W'(16);
            ring_div_reg <= CFG_DIV_W'(8);
        end else if (wr) begin
            case (idx)
                REG_RADIUS:   radius_reg   <= pwdata[15:0];
                REG_AZ_DIV:   az_div_reg   <= pwdata[CFG_DIV_W-1:0];
                REG_RING_DIV: ring_div_reg <= pwdata[CFG_DIV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_RADIUS:   prdata = 32'(radius_reg);
            REG_AZ_DIV:   prdata = 32'(az_div_reg);
            REG_RING_DIV: prdata = 32'(ring_div_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.radius   = radius_reg;
    assign cfg.az_div   = eff_div(az_div_reg);
    assign cfg.ring_div = eff_div(ring_div_reg);

endmodule

// ----- rtl/smvg_corner_seq.sv -----
`timescale 1ns / 1ps
// Cell capture and six-corner sequencer, one corner per cycle while en is high.
module smvg_corner_seq import smvg_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IDX_W-1:0] ring_in,
    input  logic [IDX_W-1:0] azim_in,
    output corner_t          corner_o
);

    logic             busy_reg;
    logic [2:0]       cnt_reg;
    logic [IDX_W-1:0] ri_reg;
    logic [IDX_W-1:0] ai_reg;
    logic             vld_reg;
    logic [CRD_W-1:0] ring_reg;
    logic [CRD_W-1:0] azim_reg;
    logic [2:0]       corner_reg;
    logic             last_reg;
    logic             take;

    // next cell taken while the last corner of the current one goes out
    assign s_tready = en && (!busy_reg || cnt_reg == LAST_CORNER);
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            vld_reg  <= 1'b0;
        end else if (en) begin
            vld_reg <= busy_reg;
            if (take) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == LAST_CORNER) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ri_reg <= ring_in;
            ai_reg <= azim_in;
        end
        if (en) begin
            ring_reg   <= CRD_W'(ri_reg) + CRD_W'(corner_dr(cnt_reg));
            azim_reg   <= CRD_W'(ai_reg) + CRD_W'(corner_da(cnt_reg));
            corner_reg <= cnt_reg;
            last_reg   <= (cnt_reg == LAST_CORNER);
        end
    end

    assign corner_o = {vld_reg, ring_reg, azim_reg, corner_reg, last_reg};

endmodule

// ----- rtl/smvg_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
module smvg_div import smvg_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num_i,
    input  logic [DEN_W-1:0] den_i,
    output logic [NUM_W-1:0] quo_o
);

    // nq holds the unconsumed numerator bits on top, quotient bits shift in below
    logic [NUM_W-1:0] nq_reg   [NUM_W];
    logic [NUM_W-1:0] nq_next  [NUM_W];
    logic [REM_W-1:0] rem_reg  [NUM_W];
    logic [REM_W-1:0] rem_next [NUM_W];
    logic [DEN_W-1:0] den_reg  [NUM_W];
    logic [DEN_W-1:0] den_next [NUM_W];

    always_comb begin
        logic [NUM_W-1:0] cur_nq;
        logic [REM_W-1:0] cur_rem;
        logic [DEN_W-1:0] cur_den;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   dx;
        logic             qbit;
        for (int i = 0; i < NUM_W; i++) begin
            if (i == 0) begin
                cur_nq  = num_i;
                cur_rem = '0;
                cur_den = den_i;
            end else begin
                cur_nq  = nq_reg[i-1];
                cur_rem = rem_reg[i-1];
                cur_den = den_reg[i-1];
            end
            trial = (DEN_W+1)'({cur_rem, cur_nq[NUM_W-1]});
            dx    = (DEN_W+1)'(cur_den);
            qbit  = (trial >= dx);
            rem_next[i] = qbit ? REM_W'(trial - dx) : REM_W'(trial);
            nq_next[i]  = {cur_nq[NUM_W-2:0], qbit};
            den_next[i] = cur_den;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg  <= nq_next;
            rem_reg <= rem_next;
            den_reg <= den_next;
        end
    end

    assign quo_o = nq_reg[NUM_W-1];

endmodule

// ----- rtl/smvg_qsin.sv -----
`timescale 1ns / 1ps
// Six-stage quarter-wave sine: degree-9 Horner polynomial in Q.30, clamped to 1.0.
module smvg_qsin import smvg_pkg::*; (
    input  logic           aclk,
    input  logic           en,
    input  logic [Q_W-1:0] t_i,
    output logic [Q_W-1:0] s_o
);

    logic [Q_W-1:0] t_reg [5];
    logic [Q_W-1:0] w_reg [4];
    logic [Q_W-1:0] a_reg [4];
    logic [Q_W-1:0] s_reg;
    logic [Q_W-1:0] fin;

    assign fin = mul_q30(t_reg[4], a_reg[3]);

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg[0] <= t_i;
            w_reg[0] <= mul_q30(t_i, t_i);
            for (int i = 1; i < 5; i++) begin
                t_reg[i] <= t_reg[i-1];
            end
            for (int i = 1; i < 4; i++) begin
                w_reg[i] <= w_reg[i-1];
            end
            a_reg[0] <= C7 - mul_q30(w_reg[0], C9);
            a_reg[1] <= C5 - mul_q30(w_reg[1], a_reg[0]);
            a_reg[2] <= C3 - mul_q30(w_reg[2], a_reg[1]);
            a_reg[3] <= C1 - mul_q30(w_reg[3], a_reg[2]);
            s_reg    <= (fin > ONE_Q30) ? ONE_Q30 : fin;
        end
    end

    assign s_o = s_reg;

endmodule

// ----- rtl/sphere_mesh_vertex_generator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the UV sphere cell vertex generator.
//
// Usage: each word on the s_ channel names one cell of a UV sphere grid
// (ring index, azimuth index). For every cell the m_ channel delivers six
// vertex words, the cell's two triangles in corner order
// (i,j) (i+1,j) (i,j+1) (i+1,j) (i+1,j+1) (i,j+1); tuser holds the corner
// number and tlast marks the sixth word.
// Radius and division counts sit in APB registers (0x0 radius Q8.8,
// 0x4 azimuth divisions, 0x8 ring divisions); change them only when idle.
// Throughput: one vertex per cycle while m_tready accepts, so one cell per six
// vertices; the corner sequencer admits a new cell during the cycle its previous
// cell's sixth corner leaves.
// Datapath: from cell acceptance to its first vertex word, the bulk of the
// pipeline is the 43-stage bit-per-stage dividers for the angle phases and
// texture coordinates, followed by the 6-stage sine polynomials.
// Reset (synchronous, aresetn low) clears all valid bits, the sequencer and
// the registers to radius 1.0, 16 slices, 8 rings.
// Stall: when m_tvalid is high and m_tready low, the whole pipeline and the
// sequencer freeze; nothing is dropped or repeated.
module sphere_mesh_vertex_generator_unit import smvg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: [9:0] ring_index, [19:10] azimuth_index, [23:20] zero
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,
    // m_tdata: [16:0] pos_x, [33:17] pos_y, [50:34] pos_z, [66:51] norm_x,
    // [82:67] norm_y, [98:83] norm_z, [117:99] tex_u, [132:118] tex_v, rest 0
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,
    // m_tuser: [2:0] corner_number
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // Stage numbering: S0 sequencer output, S1-S3 setup, dividers end at S_DIV,
    // fold at S_FOLD, sines, unit vector and scaling, output at S_OUT.
    localparam int S_DIV   = 3 + NUM_W;
    localparam int S_FOLD  = S_DIV + 1;
    localparam int S_OUT   = S_FOLD + QSIN_LAT + 4;
    localparam int TAIL_N  = S_OUT - S_FOLD;

    localparam int M1_W = CRD_W + 16;
    localparam int M2_W = M1_W + Q_W;
    localparam int PR_W = 16 + Q_W;

    typedef struct packed {
        logic [3:0]  sgn;   // sin theta, cos theta, sin phi, cos phi
        logic [18:0] tex_u;
        logic [14:0] tex_v;
    } tail_t;

    cfg_t    cfg;
    corner_t c0;
    logic    en;

    corner_t side_reg [1:S_OUT];

    // setup stages
    logic [CRD_W-1:0] r1_reg, a1_reg, r2_reg, a2_reg;
    logic [M1_W-1:0]  m1_reg;
    logic [M2_W-1:0]  m2_reg;
    logic [NUM_W-1:0] nt_reg, np_reg, nv_reg, nu_reg;
    logic [M2_W:0]    usum;

    logic [NUM_W-1:0] quo_t, quo_p, quo_v, quo_u;

    // fold stage and sines
    logic [Q_W-1:0] ts_reg, tc_reg, ps_reg, pc_reg;
    logic [Q_W-1:0] st_m, ct_m, sp_m, cp_m;
    logic [31:0]    pt_c, pp_c;
    tail_t          tail_reg [TAIL_N];

    // unit vector and scaling
    logic [2*Q_W-1:0] mx_reg, my_reg;
    logic [Q_W-1:0]   uz54_reg;
    logic [Q_W-1:0]   ux_reg, uy_reg, uz_reg;
    logic [2*Q_W-1:0] rx, ry;
    logic [PR_W-1:0]  prx_reg, pry_reg, prz_reg;
    logic [14:0]      nx_reg, ny_reg, nz_reg;

    logic signed [16:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [15:0] norm_x_reg, norm_y_reg, norm_z_reg;
    logic [18:0]        tex_u_reg;
    logic [14:0]        tex_v_reg;

    assign m_tvalid = side_reg[S_OUT].vld;
    assign en       = !m_tvalid || m_tready;

    smvg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    smvg_corner_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .ring_in  (s_tdata[IDX_W-1:0]),
        .azim_in  (s_tdata[2*IDX_W-1:IDX_W]),
        .corner_o (c0)
    );

    // corner number, last flag and valid ride alongside the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= S_OUT; i++) begin
                side_reg[i] <= '0;
            end
        end else if (en) begin
            side_reg[1] <= c0;
            for (int i = 2; i <= S_OUT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // S1-S3: u numerator a*radius*2pi, then all divider numerators
    assign usum = (M2_W+1)'(m2_reg) + ((M2_W+1)'(cfg.az_div) << 27);

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg <= c0.ring;
            a1_reg <= c0.azim;
            m1_reg <= M1_W'(c0.azim) * M1_W'(cfg.radius);
            r2_reg <= r1_reg;
            a2_reg <= a1_reg;
            m2_reg <= M2_W'(m1_reg) * M2_W'(TWO_PI_Q28);
            // theta phase r*2^31/H, phi phase a*2^32/A, both rounded
            nt_reg <= NUM_W'({r2_reg, 31'b0}) + NUM_W'(cfg.ring_div >> 1);
            np_reg <= NUM_W'({a2_reg, 32'b0}) + NUM_W'(cfg.az_div >> 1);
            nv_reg <= NUM_W'({r2_reg, 14'b0}) + NUM_W'(cfg.ring_div >> 1);
            nu_reg <= NUM_W'(usum[M2_W:28]);
        end
    end

    smvg_div u_div_t (.aclk(aclk), .en(en), .num_i(nt_reg), .den_i(cfg.ring_div),
                      .quo_o(quo_t));
    smvg_div u_div_p (.aclk(aclk), .en(en), .num_i(np_reg), .den_i(cfg.az_div),
                      .quo_o(quo_p));
    smvg_div u_div_v (.aclk(aclk), .en(en), .num_i(nv_reg), .den_i(cfg.ring_div),
                      .quo_o(quo_v));
    smvg_div u_div_u (.aclk(aclk), .en(en), .num_i(nu_reg), .den_i(cfg.az_div),
                      .quo_o(quo_u));

    // fold: quadrant odd mirrors the argument, upper half negates
    assign pt_c = quo_t[31:0];
    assign pp_c = quo_p[31:0];

    function automatic logic [Q_W-1:0] fold_arg(input logic [31:0] p);
        logic [Q_W-1:0] r;
        r = Q_W'(p[29:0]);
        return p[30] ? (ONE_Q30 - r) : r;
    endfunction

    always_ff @(posedge aclk) begin
        logic [31:0] ptc, ppc;
        ptc = pt_c + 32'h4000_0000;
        ppc = pp_c + 32'h4000_0000;
        if (en) begin
            ts_reg <= fold_arg(pt_c);
            tc_reg <= fold_arg(ptc);
            ps_reg <= fold_arg(pp_c);
            pc_reg <= fold_arg(ppc);
            tail_reg[0].sgn   <= {pt_c[31], ptc[31], pp_c[31], ppc[31]};
            tail_reg[0].tex_u <= (quo_u > NUM_W'(19'h7FFFF)) ? 19'h7FFFF : quo_u[18:0];
            tail_reg[0].tex_v <= (quo_v > NUM_W'(16384)) ? 15'd16384 : quo_v[14:0];
            for (int i = 1; i < TAIL_N; i++) begin
                tail_reg[i] <= tail_reg[i-1];
            end
        end
    end

    smvg_qsin u_sin_t (.aclk(aclk), .en(en), .t_i(ts_reg), .s_o(st_m));
    smvg_qsin u_cos_t (.aclk(aclk), .en(en), .t_i(tc_reg), .s_o(ct_m));
    smvg_qsin u_sin_p (.aclk(aclk), .en(en), .t_i(ps_reg), .s_o(sp_m));
    smvg_qsin u_cos_p (.aclk(aclk), .en(en), .t_i(pc_reg), .s_o(cp_m));

    // unit vector magnitudes, signs handled separately
    assign rx = mx_reg + (2*Q_W)'(32'h2000_0000);
    assign ry = my_reg + (2*Q_W)'(32'h2000_0000);

    always_ff @(posedge aclk) begin
        logic [Q_W:0] nrx, nry, nrz;
        nrx = (Q_W+1)'(ux_reg) + (Q_W+1)'(16'h8000);
        nry = (Q_W+1)'(uy_reg) + (Q_W+1)'(16'h8000);
        nrz = (Q_W+1)'(uz_reg) + (Q_W+1)'(16'h8000);
        if (en) begin
            mx_reg   <= (2*Q_W)'(st_m) * (2*Q_W)'(cp_m);
            my_reg   <= (2*Q_W)'(st_m) * (2*Q_W)'(sp_m);
            uz54_reg <= ct_m;
            ux_reg   <= rx[Q_W+29:30];
            uy_reg   <= ry[Q_W+29:30];
            uz_reg   <= uz54_reg;
            prx_reg  <= PR_W'(cfg.radius) * PR_W'(ux_reg);
            pry_reg  <= PR_W'(cfg.radius) * PR_W'(uy_reg);
            prz_reg  <= PR_W'(cfg.radius) * PR_W'(uz_reg);
            nx_reg   <= (nrx[Q_W:16] > 16'd16384) ? 15'd16384 : nrx[30:16];
            ny_reg   <= (nry[Q_W:16] > 16'd16384) ? 15'd16384 : nry[30:16];
            nz_reg   <= (nrz[Q_W:16] > 16'd16384) ? 15'd16384 : nrz[30:16];
        end
    end

    // output stage: round position to Q.8, clamp, apply signs
    function automatic logic signed [16:0] pos_out(input logic [PR_W-1:0] pr,
                                                   input logic neg);
        logic [PR_W-1:0] s;
        logic [16:0]     m;
        s = pr + PR_W'(32'h2000_0000);
        m = (s[PR_W-1:30] > 17'd65535) ? 17'd65535 : s[46:30];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [15:0] nrm_out(input logic [14:0] m,
                                                   input logic neg);
        logic signed [15:0] v;
        v = $signed(16'(m));
        return neg ? -v : v;
    endfunction

    always_ff @(posedge aclk) begin
        logic s_st, s_ct, s_sp, s_cp;
        {s_st, s_ct, s_sp, s_cp} = tail_reg[TAIL_N-1].sgn;
        if (en) begin
            pos_x_reg  <= pos_out(prx_reg, s_st ^ s_cp);
            pos_y_reg  <= pos_out(pry_reg, s_st ^ s_sp);
            pos_z_reg  <= pos_out(prz_reg, s_ct);
            norm_x_reg <= nrm_out(nx_reg, s_st ^ s_cp);
            norm_y_reg <= nrm_out(ny_reg, s_st ^ s_sp);
            norm_z_reg <= nrm_out(nz_reg, s_ct);
            tex_u_reg  <= tail_reg[TAIL_N-1].tex_u;
            tex_v_reg  <= tail_reg[TAIL_N-1].tex_v;
        end
    end

    assign m_tdata = {3'b000, tex_v_reg, tex_u_reg, norm_z_reg, norm_y_reg, norm_x_reg,
                      pos_z_reg, pos_y_reg, pos_x_reg};
    assign m_tuser = side_reg[S_OUT].corner;
    assign m_tlast = side_reg[S_OUT].last;

endmodule
